### hdl/lcdnib_pkg.sv
// Package: shared types, command codes and constants for the LCD nibble driver.
`default_nettype none
package lcdnib_pkg;

  localparam int COLUMNS = 20;
  localparam int ROWS    = 4;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int MAX_BYTES = 5;
  localparam int NIB_IDX_W = 4;

  localparam logic [2:0] CMD_INSTR = 3'd0;
  localparam logic [2:0] CMD_CHAR  = 3'd1;
  localparam logic [2:0] CMD_GOTO  = 3'd2;
  localparam logic [2:0] CMD_INIT  = 3'd3;
  localparam logic [2:0] CMD_DATA  = 3'd4;

  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  localparam logic [7:0] SET_ADDR = 8'h80;
  localparam logic [3:0][7:0] ROW_BASE = {8'h54, 8'h14, 8'h40, 8'h00};
  localparam logic [4:0][7:0] INIT_SEQ = {8'h06, 8'h01, 8'h0c, 8'h28, 8'h02};

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [4:0] column;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } out_item_t;

  // Up to five bytes queued for one request, each with its register select.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [MAX_BYTES-1:0]      rs;
    logic [2:0]                nbytes;
  } burst_t;

  typedef struct packed {
    logic busy;
    logic ready;
  } ser_status_t;

  function automatic logic [7:0] addr_instr(input logic [1:0] r, input logic [COL_W-1:0] c);
    return SET_ADDR + ROW_BASE[r] + 8'(c);
  endfunction

endpackage
`default_nettype wire

### hdl/char_lcd_nibble_cursor_driver.sv
// Top level: 4-bit character LCD host driver with cursor tracking.
// The request is registered into the burst register; the first nibble is then registered into the output register.
// One nibble per cycle while out_ready is high; a known request yields 2 to 10 nibbles (2 per byte, init 10).
// The next request is accepted in the cycle its predecessor's last nibble is registered.
// Unused command codes are accepted and produce nothing.
// Reset (synchronous, rst_n low): cursor to row 0 column 0, output and burst emptied.
`default_nettype none
module char_lcd_nibble_cursor_driver (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lcdnib_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lcdnib_pkg::out_item_t      out_data
);
  import lcdnib_pkg::*;

  logic        accept;
  burst_t      burst;
  ser_status_t status;

  assign in_ready = status.ready;
  assign accept   = in_valid && in_ready;

  lcdnib_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .burst  (burst)
  );

  lcdnib_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .burst_in  (burst),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

  // a request with a known code always starts a burst
  a_known_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.cmd == CMD_INSTR || in_data.cmd == CMD_CHAR ||
                in_data.cmd == CMD_GOTO || in_data.cmd == CMD_INIT ||
                in_data.cmd == CMD_DATA)) |=> status.busy)
    else $error("burst not started after request");

  // a non-final nibble that leaves must have a successor pending
  a_no_truncate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last) |=> (out_valid || status.busy))
    else $error("burst truncated");

  // nothing is accepted while a busy burst is stalled at the output
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (status.busy && out_valid && !out_ready) |-> !in_ready)
    else $error("request accepted while burst stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

### hdl/lcdnib_decode.sv
// Decoder: turns one request into a byte burst and tracks the cursor.
`default_nettype none
module lcdnib_decode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire lcdnib_pkg::in_item_t item,
  output lcdnib_pkg::burst_t      burst
);
  import lcdnib_pkg::*;

  logic [1:0]       cur_row_r, cur_row_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [COL_W:0]   col_inc;
  logic [1:0]       row_inc;
  logic [1:0]       goto_row;
  logic [COL_W-1:0] goto_col;

  always_comb begin
    col_inc = {1'b0, cur_col_r} + 1'b1;
    row_inc = (int'(cur_row_r) >= ROWS - 1) ? 2'd0 : cur_row_r + 2'd1;
    goto_row = (int'(item.row) >= ROWS) ? 2'(ROWS - 1) : item.row;
    goto_col = (int'(item.column) >= COLUMNS) ? COL_W'(COLUMNS - 1) : COL_W'(item.column);
  end

  always_comb begin
    burst.bytes  = '0;
    burst.rs     = '0;
    burst.nbytes = 3'd0;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    unique case (item.cmd)
      CMD_INSTR: begin
        burst.bytes[0] = item.byte_value;
        burst.rs[0]    = RS_INSTR;
        burst.nbytes   = 3'd1;
      end
      CMD_CHAR: begin
        burst.bytes[0] = item.byte_value;
        burst.rs[0]    = RS_DATA;
        burst.nbytes   = 3'd1;
        if (int'(col_inc) >= COLUMNS) begin
          // wrap to the start of the next row and move the display address there
          cur_col_nxt    = '0;
          cur_row_nxt    = row_inc;
          burst.bytes[1] = addr_instr(row_inc, '0);
          burst.rs[1]    = RS_INSTR;
          burst.nbytes   = 3'd2;
        end else begin
          cur_col_nxt = col_inc[COL_W-1:0];
        end
      end
      CMD_GOTO: begin
        burst.bytes[0] = addr_instr(goto_row, goto_col);
        burst.rs[0]    = RS_INSTR;
        burst.nbytes   = 3'd1;
        cur_row_nxt    = goto_row;
        cur_col_nxt    = goto_col;
      end
      CMD_INIT: begin
        burst.bytes  = INIT_SEQ;
        burst.rs     = '0;
        burst.nbytes = 3'(MAX_BYTES);
        cur_row_nxt  = '0;
        cur_col_nxt  = '0;
      end
      CMD_DATA: begin
        burst.bytes[0] = item.byte_value;
        burst.rs[0]    = RS_DATA;
        burst.nbytes   = 3'd1;
      end
      default: begin
        // drop unused codes: no burst, cursor holds
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
    end else if (accept) begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/lcdnib_serializer.sv
// Serializer: holds a byte burst and sends it out one nibble per cycle while out_ready is high.
`default_nettype none
module lcdnib_serializer (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire lcdnib_pkg::burst_t    burst_in,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output lcdnib_pkg::out_item_t      out_data,
  output lcdnib_pkg::ser_status_t    status
);
  import lcdnib_pkg::*;

  burst_t               burst_r;
  logic                 busy_r;
  logic [NIB_IDX_W-1:0] nib_idx_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic                 load_out;
  logic                 is_last;
  logic [NIB_IDX_W-1:0] last_idx;
  logic [7:0]           byte_sel;
  out_item_t            nib_nxt;
  logic                 busy_nxt;
  logic [NIB_IDX_W-1:0] nib_idx_nxt;

  always_comb begin
    load_out = busy_r && (!out_valid_r || out_ready);
    last_idx = {burst_r.nbytes, 1'b0} - 4'd1;
    is_last  = (nib_idx_r == last_idx);
    byte_sel = burst_r.bytes[nib_idx_r[3:1]];
    nib_nxt.reg_select = burst_r.rs[nib_idx_r[3:1]];
    // high nibble first
    nib_nxt.nibble = nib_idx_r[0] ? byte_sel[3:0] : byte_sel[7:4];
    nib_nxt.last   = is_last;
    status.busy    = busy_r;
    status.ready   = !busy_r || (load_out && is_last);
  end

  always_comb begin
    busy_nxt    = busy_r;
    nib_idx_nxt = nib_idx_r;
    if (load_out) begin
      if (is_last) begin
        busy_nxt    = 1'b0;
        nib_idx_nxt = '0;
      end else begin
        nib_idx_nxt = nib_idx_r + 1'b1;
      end
    end
    // a new burst takes over in the cycle the old one ends
    if (load && burst_in.nbytes != 3'd0) begin
      busy_nxt    = 1'b1;
      nib_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      nib_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      nib_idx_r <= nib_idx_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst_in;
    end
    if (load_out) begin
      out_data_r <= nib_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
